[sv/lsc_pkg.sv]
// Shared types and constants for the load shedding controller.
package lsc_pkg;

  // Width of the period register and the tick counter
  localparam int unsigned TimerW = 16;

  // Period after reset, in ticks
  localparam logic [TimerW-1:0] PeriodReset = 16'd500;

  // Per-item commands from the shedding logic to the timer
  typedef struct packed {
    logic tick;           // count one timer tick
    logic restart;        // clear the count and start the timer
    logic clear_elapsed;  // consume a pending period expiry
  } lsc_timer_ctrl_t;

endpackage

[sv/lsc_timer.sv]
// Auto-reload period timer with expiry flag and period register.
module lsc_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lsc_pkg::TimerW-1:0]  cfg_wdata_i,
  input  lsc_pkg::lsc_timer_ctrl_t    ctrl_i,
  output logic                        elapsed_o
);
  import lsc_pkg::*;

  logic [TimerW-1:0] period_q;
  logic [TimerW-1:0] cnt_q, cnt_d;
  logic              running_q, running_d;
  logic              elapsed_q, elapsed_d;
  logic [TimerW-1:0] per_eff;
  logic [TimerW-1:0] cnt_inc;

  // Treat a zero period as one tick
  assign per_eff = (period_q == '0) ? TimerW'(1) : period_q;
  assign cnt_inc = cnt_q + TimerW'(1);

  // Count ticks, reload on expiry, apply restarts
  always_comb begin
    cnt_d     = cnt_q;
    running_d = running_q;
    elapsed_d = elapsed_q;
    if (ctrl_i.clear_elapsed) begin
      elapsed_d = 1'b0;
    end
    if (ctrl_i.restart) begin
      cnt_d     = '0;
      running_d = 1'b1;
    end
    if (ctrl_i.tick && running_q) begin
      if (cnt_inc >= per_eff) begin
        cnt_d     = '0;
        elapsed_d = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // Hold period and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PeriodReset;
      cnt_q     <= '0;
      running_q <= 1'b0;
      elapsed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      cnt_q     <= cnt_d;
      running_q <= running_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign elapsed_o = elapsed_q;

endmodule

[sv/load_shedding_controller.sv]
// Top level: stability-driven load shedding controller with stream ports.
//
//  channel   dir  handshake                tdata (low bit up)               tuser
//  s_axis    in   s_axis_tvalid/tready     stable_flag, switch_loads,       mode
//                                          managed_mode, zero pad
//  m_axis    out  m_axis_tvalid/tready     load_enables, shedding_active,   -
//                                          zero pad
//  cfg       in   cfg_we                   period_ticks (16 bits)           -
//
// One item per cycle sustained while no result waits; an item leaves the input register
// when it fires, and its result, if any, appears in the output register on the next cycle.
// The shedding state and timer update in the single cycle the item leaves the
// input register. Reset clears the valid flags, shedding and timer state and sets the period to 500 ticks.
// An item that yields a result waits in the input register while the output
// register is full and not being taken; items without a result never wait.
module load_shedding_controller #(
  parameter  int unsigned NUM_LOADS = 5,
  localparam int unsigned InDataW   = ((NUM_LOADS + 2 + 7) / 8) * 8,
  localparam int unsigned OutDataW  = ((NUM_LOADS + 1 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [lsc_pkg::TimerW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [InDataW-1:0]          s_axis_tdata_i,  // stable_flag, switch_loads, managed_mode
  input  logic                        s_axis_tuser_i,  // mode: 0 report, 1 timer tick
  // output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [OutDataW-1:0]         m_axis_tdata_o   // load_enables, shedding_active
);
  import lsc_pkg::*;

  // Input register
  logic                 in_valid_q;
  logic                 in_tick_q;
  logic                 in_stable_q;
  logic [NUM_LOADS-1:0] in_sw_q;
  logic                 in_managed_q;

  // Shedding state
  logic                 managing_q, managing_d;
  logic [NUM_LOADS-1:0] init_q, init_d;
  logic [NUM_LOADS-1:0] cur_q, cur_d;
  logic                 lws_q, lws_d;

  // Result register
  logic                 out_valid_q;
  logic [NUM_LOADS-1:0] out_loads_q;
  logic                 out_shed_q;

  logic                 has_result;
  logic                 res_shed;
  logic                 out_free;
  logic                 fire;
  logic                 s_xfer;
  logic                 elapsed;
  logic [NUM_LOADS-1:0] miss;
  logic [NUM_LOADS-1:0] restore_hot;
  lsc_timer_ctrl_t      ctrl, ctrl_gated;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && (!has_result || out_free);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  // Highest-numbered shed load that was initially on
  assign miss = init_q & ~cur_q;
  always_comb begin
    restore_hot = '0;
    for (int i = 0; i < NUM_LOADS; i++) begin
      if (miss[i]) begin
        restore_hot = NUM_LOADS'(1) << i;
      end
    end
  end

  // Decide the next shedding state and the result for the held item
  always_comb begin
    logic                 m;
    logic                 lws;
    logic [NUM_LOADS-1:0] ini;
    logic [NUM_LOADS-1:0] cur;
    logic                 changed;
    m          = managing_q;
    lws        = lws_q;
    ini        = init_q;
    cur        = cur_q;
    changed    = 1'b0;
    ctrl       = '0;
    has_result = 1'b0;
    res_shed   = 1'b0;
    managing_d = managing_q;
    init_d     = init_q;
    cur_d      = cur_q;
    lws_d      = lws_q;
    if (in_tick_q) begin
      ctrl.tick = 1'b1;
    end else if (!in_managed_q) begin
      // pass switches through and leave shedding
      managing_d = 1'b0;
      cur        = in_sw_q;
      has_result = 1'b1;
    end else begin
      // enter shedding on the first unstable report
      if (!in_stable_q && !m) begin
        m            = 1'b1;
        ini          = in_sw_q;
        cur          = in_sw_q;
        lws          = 1'b0;
        ctrl.restart = 1'b1;
      end
      if (m) begin
        if (in_stable_q) begin
          if (!lws) begin
            ctrl.restart = 1'b1;
          end else if (elapsed) begin
            ctrl.clear_elapsed = 1'b1;
            ctrl.restart       = 1'b1;
            if (restore_hot != '0) begin
              cur     = cur | restore_hot;
              changed = 1'b1;
            end
          end
          lws = 1'b1;
          if (cur == ini) begin
            m = 1'b0;
          end
        end else begin
          if (lws) begin
            ctrl.restart = 1'b1;
          end else if (elapsed || (cur == ini)) begin
            ctrl.clear_elapsed = 1'b1;
            ctrl.restart       = 1'b1;
            if (cur != '0) begin
              cur     = cur & (cur - NUM_LOADS'(1));
              changed = 1'b1;
            end
          end
          lws = 1'b0;
        end
      end
      managing_d = m;
      init_d     = ini;
      cur_d      = cur;
      lws_d      = lws;
      has_result = changed;
      res_shed   = m;
    end
    if (!in_managed_q || in_tick_q) begin
      // pass-through result carries the switches; current loads stay
      cur_d = cur_q;
    end
  end

  // Block timer commands unless the item leaves the input register
  assign ctrl_gated = fire ? ctrl : '0;

  lsc_timer u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl_gated),
    .elapsed_o   (elapsed)
  );

  // Input register: load on transfer, drop when the item fires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_tick_q    <= s_axis_tuser_i;
      in_stable_q  <= s_axis_tdata_i[0];
      in_sw_q      <= s_axis_tdata_i[NUM_LOADS:1];
      in_managed_q <= s_axis_tdata_i[NUM_LOADS+1];
    end
  end

  // Shedding state: advance when the item fires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      managing_q <= 1'b0;
      init_q     <= '0;
      cur_q      <= '0;
      lws_q      <= 1'b0;
    end else if (fire) begin
      managing_q <= managing_d;
      init_q     <= init_d;
      cur_q      <= cur_d;
      lws_q      <= lws_d;
    end
  end

  // Result register: load on a firing result, drop on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      out_loads_q <= in_managed_q ? cur_d : in_sw_q;
      out_shed_q  <= res_shed;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_shed_q, out_loads_q});

  // Current loads never include a load outside the initial pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q & ~init_q) == '0)
    else $error("current loads outside initial loads");

  // A firing result is in the output register on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_result) |=> out_valid_q)
    else $error("result lost on fire");

  // A result never fires over a waiting, untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && in_valid_q && has_result) |-> !fire)
    else $error("result overwrote pending output");

endmodule
